@@ rtl/dsf_pkg.sv @@
// Shared types, constants and the mask arithmetic of the directional Sobel filter.
// Used by the channel interfaces, the line store and the top level.
// No dependencies.
package dsf_pkg;

   // Area limits and derived widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Fixed field widths of the channels
   localparam int PIXEL_W    = 8;
   localparam int VALUE_W    = 8;
   localparam int POS_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int DIR_W      = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_HEIGHT = 2'd2;

   // Mask codes
   localparam logic [DIR_W-1:0] DIR_TOP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_BOTTOM = 2'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd3;

   // One line store entry: the pixels one and two rows above
   typedef struct packed {
      logic [PIXEL_W-1:0] above2;
      logic [PIXEL_W-1:0] above1;
   } ls_entry_type;

   // Access request from the pipeline to the line store
   typedef struct packed {
      logic             rd_en;
      logic [COL_W-1:0] rd_addr;
      logic             wr_en;
      logic [COL_W-1:0] wr_addr;
      ls_entry_type     wr_data;
   } ls_req_type;

   // Mask sum modulo 256. win[k] is the left column, win[3+k] the middle one,
   // cur[k] the right one; k = 0 is the top row.
   function automatic logic [VALUE_W-1:0] sobel_value(
      input logic [DIR_W-1:0]             dir,
      input logic [5:0][PIXEL_W-1:0]      win,
      input logic [2:0][PIXEL_W-1:0]      cur
   );
      logic [VALUE_W-1:0] top_row;
      logic [VALUE_W-1:0] bot_row;
      logic [VALUE_W-1:0] left_col;
      logic [VALUE_W-1:0] right_col;
      logic [VALUE_W-1:0] vert;
      logic [VALUE_W-1:0] horz;
      logic [VALUE_W-1:0] res;
      top_row   = win[0] + {win[3][PIXEL_W-2:0], 1'b0} + cur[0];
      bot_row   = win[2] + {win[5][PIXEL_W-2:0], 1'b0} + cur[2];
      left_col  = win[0] + {win[1][PIXEL_W-2:0], 1'b0} + win[2];
      right_col = cur[0] + {cur[1][PIXEL_W-2:0], 1'b0} + cur[2];
      vert      = bot_row - top_row;
      horz      = right_col - left_col;
      case (dir)
         DIR_TOP:    res = vert;
         DIR_BOTTOM: res = VALUE_W'(0) - vert;
         DIR_RIGHT:  res = horz;
         DIR_LEFT:   res = VALUE_W'(0) - horz;
         default:    res = vert;
      endcase
      return res;
   endfunction

endpackage

@@ rtl/dsf_if.sv @@
// Valid/ready channel interfaces of the directional Sobel filter:
// pixel input, result output and register write port.
// Depends on dsf_pkg.
interface dsf_req_if;
   import dsf_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface dsf_rsp_if;
   import dsf_pkg::*;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [POS_W-1:0]   row;
   logic [POS_W-1:0]   column;
   logic               last;
   modport source (output valid, output value, output row, output column, output last,
                   input ready);
   modport sink   (input valid, input value, input row, input column, input last,
                   output ready);
endinterface

interface dsf_csr_if;
   import dsf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/dsf_line_store.sv @@
// Two-row line store: one synchronous memory, one entry per column, with a
// registered read and a bypass for a write to the entry read at the same edge.
// Depends on dsf_pkg.
module dsf_line_store (
   input  logic                  clock,
   input  logic                  reset,
   input  dsf_pkg::ls_req_type   ls_req,
   output dsf_pkg::ls_entry_type rd_data
);
   import dsf_pkg::*;

   ls_entry_type line_mem_ff [MAX_WIDTH];
   ls_entry_type rd_data_ff;
   ls_entry_type byp_data_ff;
   logic         byp_sel_ff;
   logic         byp_sel_in;

   // Memory port: read-before-write, registered read data
   always_ff @(posedge clock) begin
      if (ls_req.wr_en) begin
         line_mem_ff[ls_req.wr_addr] <= ls_req.wr_data;
      end
      if (ls_req.rd_en) begin
         rd_data_ff  <= line_mem_ff[ls_req.rd_addr];
         byp_data_ff <= ls_req.wr_data;
      end
   end

   // Same-entry hazard: a read that collides with a write takes the new data
   assign byp_sel_in = ls_req.rd_en ? (ls_req.wr_en && ls_req.wr_addr == ls_req.rd_addr)
                                    : byp_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_sel_ff <= 1'b0;
      end else begin
         byp_sel_ff <= byp_sel_in;
      end
   end

   assign rd_data = byp_sel_ff ? byp_data_ff : rd_data_ff;

endmodule

@@ rtl/directional_sobel_filter_unit.sv @@
// Directional 3x3 Sobel filter over a raster-order pixel area.
// Depends on dsf_pkg, dsf_if and dsf_line_store.

// One pixel is taken per cycle, back to back, unless a stalled result channel
// holds it up; a result passes the line store read, then the output register.
// The rate is set by the single line store memory, which is read and written
// once per pixel. Only interior pixels give a result (with its area row and
// column and a flag on the final one); border pixels give none. The selected
// mask sum is reduced to its low 8 bits. Register writes are taken at any
// time but should be made only while no pixel is in flight. Line store
// contents are undefined after reset; there is no clearing pass.
module directional_sobel_filter_unit (
   input  logic          clock,
   input  logic          reset,
   dsf_req_if.sink       req_in,
   dsf_rsp_if.source     rsp_out,
   dsf_csr_if.sink       csr_in
);
   import dsf_pkg::*;

   // Configuration
   logic [DIR_W-1:0] dir_ff;
   logic [COL_W-1:0] width_last_ff;
   logic [ROW_W-1:0] height_last_ff;
   logic             csr_write;

   // Position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             row_end, area_end, req_accept;

   // Stage 1: line store data available
   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic               s1_emit_ff;
   logic               s1_last_ff;
   logic               s1_advance;

   logic [5:0][PIXEL_W-1:0] win_ff;
   logic [2:0][PIXEL_W-1:0] cur;

   ls_req_type   ls_req;
   ls_entry_type ls_rd;

   // Output register
   logic               out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0] out_value_ff;
   logic [POS_W-1:0]   out_row_ff;
   logic [POS_W-1:0]   out_col_ff;
   logic               out_last_ff;
   logic               out_load;

   // Register writes, sizes held as last index after clamping to 1..max
   assign csr_in.ready = 1'b1;
   assign csr_write    = csr_in.valid && csr_in.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff         <= DIR_TOP;
         width_last_ff  <= COL_W'(MAX_WIDTH - 1);
         height_last_ff <= ROW_W'(MAX_HEIGHT - 1);
      end else if (csr_write) begin
         case (csr_in.index)
            CSR_DIRECTION:   dir_ff <= csr_in.data[DIR_W-1:0];
            CSR_AREA_WIDTH: begin
               if (csr_in.data == '0) begin
                  width_last_ff <= '0;
               end else if (32'(csr_in.data) > MAX_WIDTH) begin
                  width_last_ff <= COL_W'(MAX_WIDTH - 1);
               end else begin
                  width_last_ff <= COL_W'(csr_in.data - CSR_DATA_W'(1));
               end
            end
            CSR_AREA_HEIGHT: begin
               if (csr_in.data == '0) begin
                  height_last_ff <= '0;
               end else if (32'(csr_in.data) > MAX_HEIGHT) begin
                  height_last_ff <= ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  height_last_ff <= ROW_W'(csr_in.data - CSR_DATA_W'(1));
               end
            end
            default: ;
         endcase
      end
   end

   // Input handshake: stage 1 frees up when its result can move on
   assign s1_advance   = s1_valid_ff && (!s1_emit_ff || !out_valid_ff || rsp_out.ready);
   assign req_in.ready = !s1_valid_ff || s1_advance;
   assign req_accept   = req_in.valid && req_in.ready;

   // Raster position of the next pixel
   assign row_end  = col_ff >= width_last_ff;
   assign area_end = row_end && (row_ff >= height_last_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = area_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1 registers
   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_in.pixel;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_emit_ff  <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_last_ff  <= area_end;
      end
   end

   // Line store: read at acceptance, shift the column down at stage 1
   assign ls_req.rd_en          = req_accept;
   assign ls_req.rd_addr        = col_ff;
   assign ls_req.wr_en          = s1_advance;
   assign ls_req.wr_addr        = s1_col_ff;
   assign ls_req.wr_data.above2 = ls_rd.above1;
   assign ls_req.wr_data.above1 = s1_pixel_ff;

   dsf_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .ls_req  (ls_req),
      .rd_data (ls_rd)
   );

   // Current column of the window, top to bottom
   assign cur[0] = ls_rd.above2;
   assign cur[1] = ls_rd.above1;
   assign cur[2] = s1_pixel_ff;

   // Window shift: left column takes the middle, middle takes the current
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_advance) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k]     <= win_ff[3+k];
            win_ff[3+k]   <= cur[k];
         end
      end
   end

   // Output register
   assign out_load     = s1_advance && s1_emit_ff;
   assign out_valid_in = out_load ? 1'b1 : (rsp_out.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff <= sobel_value(dir_ff, win_ff, cur);
         out_row_ff   <= POS_W'(s1_row_ff) - POS_W'(1);
         out_col_ff   <= POS_W'(s1_col_ff) - POS_W'(1);
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_out.valid  = out_valid_ff;
   assign rsp_out.value  = out_value_ff;
   assign rsp_out.row    = out_row_ff;
   assign rsp_out.column = out_col_ff;
   assign rsp_out.last   = out_last_ff;

   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_out.ready))
      else $error("result register overwritten while pending");

   // A stalled stage 1 keeps its pixel and position
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_col_ff)
                                        && $stable(s1_pixel_ff)))
      else $error("stage 1 lost its pixel during a stall");

   // An accepted pixel always reaches stage 1
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted pixel not held in stage 1");

   // Interior results never carry a border position
   a_interior: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_row_ff != '0 && out_col_ff != '0))
      else $error("result at a border position");

endmodule

@@ verif/dsf_result_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the directional Sobel filter: tracks register writes and pixel
// transactions, predicts each interior result and compares the result channel against it.
// Depends on dsf_pkg and the channel interfaces in dsf_if.
module dsf_result_checker (
   input  logic clock,
   input  logic reset,
   dsf_req_if   req_mon,
   dsf_rsp_if   rsp_mon,
   dsf_csr_if   csr_mon,
   input  logic drained,
   output int   mismatches,
   output int   outstanding
);
   import dsf_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   column;
      logic               last;
   } sobel_result_type;

   sobel_result_type      expected_results [$];

   // Shadow of the filter: registers, the two rows above and the last two columns
   logic [DIR_W-1:0]      mask_dir;
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;
   logic [PIXEL_W-1:0]    row_above1 [MAX_WIDTH];
   logic [PIXEL_W-1:0]    row_above2 [MAX_WIDTH];
   logic [PIXEL_W-1:0]    prev_cols [6];
   int unsigned           row_pos;
   int unsigned           col_pos;

   int fail_count    = 0;
   int waiting_count = 0;
   bit leftovers_done = 1'b0;

   assign mismatches  = fail_count;
   assign outstanding = waiting_count;

   // One line per mismatch
   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : track_filter
      int unsigned        w;
      int unsigned        h;
      int unsigned        c;
      int unsigned        r;
      int                 sum;
      int                 weight;
      bit                 row_done;
      bit                 area_done;
      logic [PIXEL_W-1:0] col_now [3];
      logic [PIXEL_W-1:0] nb [3][3];
      sobel_result_type   got;
      sobel_result_type   want;

      if (reset) begin
         mask_dir   = DIR_TOP;
         width_reg  = CSR_DATA_W'(MAX_WIDTH);
         height_reg = CSR_DATA_W'(MAX_HEIGHT);
         foreach (prev_cols[i]) prev_cols[i] = '0;
         row_pos = 0;
         col_pos = 0;
         expected_results.delete();
      end else begin
         // register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_DIRECTION:   mask_dir   = csr_mon.data[DIR_W-1:0];
               CSR_AREA_WIDTH:  width_reg  = csr_mon.data;
               CSR_AREA_HEIGHT: height_reg = csr_mon.data;
               default: ;
            endcase
         end

         // pixel transaction: update line stores and window, predict a result
         if (req_mon.valid && req_mon.ready) begin
            w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
            c = col_pos;
            r = row_pos;
            row_done  = (c >= w - 1);
            area_done = row_done && (r >= h - 1);

            col_now[0] = row_above2[c];
            col_now[1] = row_above1[c];
            col_now[2] = req_mon.pixel;
            row_above2[c] = row_above1[c];
            row_above1[c] = req_mon.pixel;

            if (r >= 2 && c >= 2) begin
               // nb[row][column], column 2 is the newest
               for (int k = 0; k < 3; k++) begin
                  nb[k][0] = prev_cols[k];
                  nb[k][1] = prev_cols[3 + k];
                  nb[k][2] = col_now[k];
               end
               // 1-2-1 weights along the edge, difference across it
               sum = 0;
               for (int k = 0; k < 3; k++) begin
                  weight = (k == 1) ? 2 : 1;
                  case (mask_dir)
                     DIR_TOP:    sum += weight * (int'(nb[2][k]) - int'(nb[0][k]));
                     DIR_BOTTOM: sum += weight * (int'(nb[0][k]) - int'(nb[2][k]));
                     DIR_RIGHT:  sum += weight * (int'(nb[k][2]) - int'(nb[k][0]));
                     DIR_LEFT:   sum += weight * (int'(nb[k][0]) - int'(nb[k][2]));
                  endcase
               end
               want.value  = sum[VALUE_W-1:0];
               want.row    = POS_W'(r - 1);
               want.column = POS_W'(c - 1);
               want.last   = area_done;
               expected_results.push_back(want);
            end

            for (int k = 0; k < 3; k++) begin
               prev_cols[k]     = prev_cols[3 + k];
               prev_cols[3 + k] = col_now[k];
            end

            if (row_done) begin
               col_pos = 0;
               row_pos = area_done ? 0 : r + 1;
            end else begin
               col_pos = c + 1;
            end
         end

         // result transaction: compare with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.value  = rsp_mon.value;
            got.row    = rsp_mon.row;
            got.column = rsp_mon.column;
            got.last   = rsp_mon.last;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result value %h row %0d column %0d last %b",
                                         got.value, got.row, got.column, got.last));
            end else begin
               want = expected_results.pop_front();
               if (got.value !== want.value)
                  report_mismatch($sformatf("value at row %0d column %0d: got %h, want %h",
                                            want.row, want.column, got.value, want.value));
               if (got.row !== want.row)
                  report_mismatch($sformatf("row: got %0d, want %0d", got.row, want.row));
               if (got.column !== want.column)
                  report_mismatch($sformatf("column at row %0d: got %0d, want %0d",
                                            want.row, got.column, want.column));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last at row %0d column %0d: got %b, want %b",
                                            want.row, want.column, got.last, want.last));
            end
         end

         // end of run: anything still predicted never arrived
         if (drained && !leftovers_done) begin
            leftovers_done = 1'b1;
            foreach (expected_results[i])
               report_mismatch($sformatf("missing result row %0d column %0d",
                                         expected_results[i].row,
                                         expected_results[i].column));
         end
      end
      waiting_count <= expected_results.size();
   end

endmodule

@@ verif/directional_sobel_filter_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the directional Sobel filter: clock, reset, pixel and register
// stimulus, result-side stalls and the verdict. Depends on dsf_pkg, dsf_if, the filter
// RTL and dsf_result_checker.
module directional_sobel_filter_unit_test;
   import dsf_pkg::*;

   localparam int RANDOM_PIXELS = 500;
   localparam int CALM_AFTER    = 400;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT   = 20000;

   // pixel content styles
   localparam int STYLE_NOISE = 0;
   localparam int STYLE_RAILS = 1;

   // register change made between two pixels of an area
   localparam int PAUSE_NONE   = 0;
   localparam int PAUSE_DIR    = 1;
   localparam int PAUSE_WIDTH  = 2;
   localparam int PAUSE_HEIGHT = 3;

   logic clock = 1'b0;
   logic reset;
   logic drained;
   int   idle_odds  = 0;
   int   stall_left = 0;
   int   mismatches;
   int   outstanding;

   dsf_req_if req_if ();
   dsf_rsp_if rsp_if ();
   dsf_csr_if csr_if ();

   directional_sobel_filter_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_if),
      .rsp_out (rsp_if),
      .csr_in  (csr_if)
   );

   dsf_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_mon     (csr_if),
      .drained     (drained),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   // run limit
   initial begin
      #(24_000_000);
      $display("FAIL");
      $finish;
   end

   // result side: random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 12);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   function automatic logic [PIXEL_W-1:0] pick_pixel(input int style);
      if (style == STYLE_RAILS)
         return $urandom_range(0, 1) ? {PIXEL_W{1'b1}} : {PIXEL_W{1'b0}};
      return PIXEL_W'($urandom_range(0, 255));
   endfunction

   // one pixel transaction, maybe after a gap; valid stays up for the next one
   task automatic send_pixel(input logic [PIXEL_W-1:0] p);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.pixel <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val,
                            input bit drop_after);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= CSR_DATA_W'(val);
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (drop_after) csr_if.valid <= 1'b0;
   endtask

   // stop sending, wait for every predicted result, then let the pipeline settle
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // configure and stream one complete area, optionally changing a register midway
   task automatic run_area(input int w_cfg, input int h_cfg, input logic [DIR_W-1:0] dir,
                           input int style, input int pause_at, input int pause_kind,
                           output int pixels_sent);
      logic [CSR_IDX_W-1:0] order [3];
      int                   vals [3];
      int                   first;
      int                   cw;
      int                   ch;
      int                   total;
      int                   r;
      int                   c;
      int                   nv;
      order = '{CSR_DIRECTION, CSR_AREA_WIDTH, CSR_AREA_HEIGHT};
      vals  = '{int'(dir), w_cfg, h_cfg};
      first = $urandom_range(0, 2);
      wait_idle();
      for (int i = 0; i < 3; i++)
         write_reg(order[(first + i) % 3], vals[(first + i) % 3], i == 2);
      cw = (w_cfg < 1) ? 1 : (w_cfg > MAX_WIDTH) ? MAX_WIDTH : w_cfg;
      ch = (h_cfg < 1) ? 1 : (h_cfg > MAX_HEIGHT) ? MAX_HEIGHT : h_cfg;
      total = cw * ch;
      for (int k = 0; k < total; k++) begin
         if (k == pause_at && pause_kind != PAUSE_NONE) begin
            wait_idle();
            r = k / cw;
            c = k % cw;
            case (pause_kind)
               PAUSE_DIR: write_reg(CSR_DIRECTION, $urandom_range(0, 3), 1'b1);
               PAUSE_WIDTH: begin
                  // only shrink: a wider row would read unwritten line store entries
                  nv = $urandom_range(1, cw);
                  write_reg(CSR_AREA_WIDTH, nv, 1'b1);
                  cw = nv;
               end
               default: begin
                  nv = $urandom_range(0, 10);
                  write_reg(CSR_AREA_HEIGHT, nv, 1'b1);
                  ch = (nv < 1) ? 1 : nv;
               end
            endcase
            // pixels still needed to close the area under the new size
            total = k + ((c >= cw) ? 1 : cw - c) + ((r >= ch - 1) ? 0 : (ch - 1 - r) * cw);
         end
         send_pixel(pick_pixel(style));
      end
      pixels_sent = total;
   endtask

   initial begin : stimulus
      int sent;
      int n;
      int w;
      int h;
      int kind;
      int waited;

      reset          = 1'b1;
      drained        = 1'b0;
      req_if.valid   = 1'b0;
      req_if.pixel   = '0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_DIRECTION;
      csr_if.data    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      idle_odds = 4;

      // reset setup: full width, top mask; cut the height to 3 once inside row 2
      for (int k = 0; k < 2 * MAX_WIDTH + 5; k++) send_pixel(pick_pixel(STYLE_NOISE));
      wait_idle();
      write_reg(CSR_AREA_HEIGHT, 3, 1'b1);
      for (int k = 0; k < MAX_WIDTH - 5; k++) send_pixel(pick_pixel(STYLE_NOISE));

      // every mask on full-scale pixels, so sums wrap both ways
      run_area(3, 3, DIR_TOP,    STYLE_RAILS, 0, PAUSE_NONE, n);
      run_area(3, 3, DIR_BOTTOM, STYLE_RAILS, 0, PAUSE_NONE, n);
      run_area(3, 3, DIR_RIGHT,  STYLE_RAILS, 0, PAUSE_NONE, n);
      run_area(3, 3, DIR_LEFT,   STYLE_RAILS, 0, PAUSE_NONE, n);

      // no interior; zero sizes act as 1, oversized ones as the maximum
      run_area(0, 3, DIR_RIGHT, STYLE_NOISE, 0, PAUSE_NONE, n);
      run_area(2, 2, DIR_LEFT,  STYLE_NOISE, 0, PAUSE_NONE, n);
      run_area(3, 0, DIR_TOP,   STYLE_NOISE, 0, PAUSE_NONE, n);
      run_area(2047, 1, DIR_BOTTOM, STYLE_NOISE, 0, PAUSE_NONE, n);
      run_area(1, 2047, DIR_LEFT, STYLE_NOISE, 0, PAUSE_NONE, n);

      // changes inside an area
      run_area(5, 5, DIR_TOP,    STYLE_NOISE, 12, PAUSE_DIR,    n);
      run_area(6, 4, DIR_RIGHT,  STYLE_NOISE, 15, PAUSE_WIDTH,  n);
      run_area(4, 6, DIR_BOTTOM, STYLE_NOISE, 9,  PAUSE_HEIGHT, n);

      // random areas, mostly well-formed, some without interior or resized midway
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         if (sent >= CALM_AFTER) idle_odds = 0;
         else idle_odds = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 3 : 10);
         case ($urandom_range(0, 9))
            0: begin
               w = $urandom_range(0, 2);
               h = $urandom_range(0, 6);
            end
            1: begin
               w = $urandom_range(3, 8);
               h = $urandom_range(0, 2);
            end
            default: begin
               w = $urandom_range(3, 12);
               h = $urandom_range(3, 8);
            end
         endcase
         kind = ($urandom_range(0, 3) == 0) ? $urandom_range(PAUSE_DIR, PAUSE_HEIGHT)
                                             : PAUSE_NONE;
         run_area(w, h, DIR_W'($urandom_range(0, 3)),
                  ($urandom_range(0, 2) == 0) ? STYLE_RAILS : STYLE_NOISE,
                  $urandom_range(0, w * h), kind, n);
         sent += n;
      end

      // drain and decide
      req_if.valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      drained <= 1'b1;
      repeat (3) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/dsf_pkg.sv
rtl/dsf_if.sv
rtl/dsf_line_store.sv
rtl/directional_sobel_filter_unit.sv
verif/dsf_result_checker.sv
verif/directional_sobel_filter_unit_test.sv
